@@ src/sorted_multiset_list_core_assert.svh @@
// Assertion macros shared by the sorted multiset list RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SORTED_MULTISET_LIST_CORE_ASSERT_SVH
`define SORTED_MULTISET_LIST_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define SML_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define SML_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define SML_ASSERT(lbl, prop, msg)
`define SML_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ src/sml_pkg.sv @@
// Package for the sorted multiset list: sizes, codes, states and structs.
// Used by every file of the block but the assertion header; depends on nothing.
package sml_pkg;

	// Storage sizes
	localparam int CAPACITY  = 32;
	localparam int MAX_VALUE = 13;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CIDX_W    = $clog2(MAX_VALUE);

	// Field widths
	localparam int CMD_W      = 2;
	localparam int VAL_W      = 4;
	localparam int STATUS_W   = 3;
	localparam int LIMIT_W    = 6;
	localparam int COPY_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LIMIT_W;
	localparam int LIM_CMP_W  = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

	// Register reset values
	localparam logic [LIMIT_W-1:0] RESET_LIST_LIMIT = LIMIT_W'(20);
	localparam logic [COPY_W-1:0]  RESET_COPY_LIMIT = COPY_W'(4);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_INVALID  = 3'd2,
		STAT_COPY     = 3'd3,
		STAT_NOT_HELD = 3'd4,
		STAT_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIST_LIMIT = 2'd0,
		REG_COPY_LIMIT = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_RM_RUN,
		ST_RD_EMIT,
		ST_RESP
	} state_t;

	// Effective limits handed to the sequencer
	typedef struct packed {
		logic [CNT_W-1:0]  lim;
		logic [COPY_W-1:0] copy_limit;
	} sml_cfg_t;

	// One result item
	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] entry;
		logic             last;
	} sml_res_t;

	// Entry memory access for one cycle
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} sml_ram_req_t;

endpackage

@@ src/sml_intf.sv @@
// Handshake interfaces for the command, result and configuration channels.
// Depends on sml_pkg for the field widths.
interface sml_req_if;
	logic                      valid;
	logic                      ready;
	logic [sml_pkg::CMD_W-1:0] cmd;
	logic [sml_pkg::VAL_W-1:0] value;

	modport source(output valid, cmd, value, input ready);
	modport sink(input valid, cmd, value, output ready);
endinterface

interface sml_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [sml_pkg::STATUS_W-1:0] status;
	logic [sml_pkg::VAL_W-1:0]    entry;
	logic                         last;

	modport source(output valid, status, entry, last, input ready);
	modport sink(input valid, status, entry, last, output ready);
endinterface

interface sml_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sml_pkg::CFG_IDX_W-1:0]  index;
	logic [sml_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ src/sml_ram.sv @@
// Entry memory of the sorted list: one write port and one registered read port.
// Depends on sml_pkg for its depth, widths and access struct.
module sml_ram (
	input  logic                      clk,
	input  sml_pkg::sml_ram_req_t     req,
	output logic [sml_pkg::VAL_W-1:0] rdata
);

	logic [sml_pkg::VAL_W-1:0] mem_q [sml_pkg::CAPACITY];
	logic [sml_pkg::VAL_W-1:0] rdata_q;

	// Write and registered read; the read data holds until the next read.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/sml_seq.sv @@
// Command sequencer: checks, shifts and scans the entry memory one entry a cycle, a read
// holding while res_ready is low, and keeps the entry total and the per-value counts. Depends on sml_pkg.
`include "sorted_multiset_list_core_assert.svh"

module sml_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [sml_pkg::CMD_W-1:0]   req_cmd,
	input  logic [sml_pkg::VAL_W-1:0]   req_value,
	output logic                        req_ready,
	input  sml_pkg::sml_cfg_t           cfg,
	output logic                        res_valid,
	output sml_pkg::sml_res_t           res,
	input  logic                        res_ready,
	output sml_pkg::sml_ram_req_t       ram_req,
	input  logic [sml_pkg::VAL_W-1:0]   ram_rdata
);

	sml_pkg::state_t                  state_q, state_d;
	logic [sml_pkg::CMD_W-1:0]        op_q;
	logic [sml_pkg::VAL_W-1:0]        val_q;
	logic [sml_pkg::CNT_W-1:0]        total_q;
	logic [sml_pkg::COPY_W-1:0]       counts_q [sml_pkg::MAX_VALUE];
	logic [sml_pkg::CNT_W-1:0]        p_q, p_d;
	logic                             found_q, found_d;
	sml_pkg::status_t                 status_q, status_d;

	logic [sml_pkg::VAL_W-1:0]        val_m1;
	logic [sml_pkg::CIDX_W-1:0]       cidx;
	logic                             val_ok;
	logic [sml_pkg::COPY_W-1:0]       cur_cnt;
	logic [sml_pkg::CNT_W-1:0]        p_m1, p_m2, p_p1, tot_m1;
	logic                             rd_last;
	logic                             commit;

	// Value decode and counter lookup for the latched command
	assign val_m1  = val_q - sml_pkg::VAL_W'(1);
	assign cidx    = val_m1[sml_pkg::CIDX_W-1:0];
	assign val_ok  = (val_q != '0) && (val_q <= sml_pkg::VAL_W'(sml_pkg::MAX_VALUE));
	assign cur_cnt = val_ok ? counts_q[cidx] : '0;

	// Position arithmetic around the walking pointer
	assign p_m1    = p_q - sml_pkg::CNT_W'(1);
	assign p_m2    = p_q - sml_pkg::CNT_W'(2);
	assign p_p1    = p_q + sml_pkg::CNT_W'(1);
	assign tot_m1  = total_q - sml_pkg::CNT_W'(1);
	assign rd_last = (p_q == tot_m1);

	// The total and counts of a successful insert or remove change when its result is handed over.
	assign commit = (state_q == sml_pkg::ST_RESP) && res_ready &&
	                (status_q == sml_pkg::STAT_OK);

	// Next state, memory access and result
	always_comb begin
		state_d   = state_q;
		p_d       = p_q;
		found_d   = found_q;
		status_d  = status_q;
		ram_req   = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		res       = '{status: status_q, entry: '0, last: 1'b1};

		unique case (state_q)
			sml_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = sml_pkg::ST_CHECK;
				end
			end

			sml_pkg::ST_CHECK: begin
				unique case (op_q)
					sml_pkg::CMD_INSERT: begin
						state_d = sml_pkg::ST_RESP;
						if (total_q >= cfg.lim) begin
							status_d = sml_pkg::STAT_FULL;
						end else if (!val_ok) begin
							status_d = sml_pkg::STAT_INVALID;
						end else if (cur_cnt >= cfg.copy_limit) begin
							status_d = sml_pkg::STAT_COPY;
						end else if (total_q == '0) begin
							ram_req.we    = 1'b1;
							ram_req.waddr = '0;
							ram_req.wdata = val_q;
							status_d      = sml_pkg::STAT_OK;
						end else begin
							// Start at the tail and walk down past larger entries.
							ram_req.re    = 1'b1;
							ram_req.raddr = tot_m1[sml_pkg::ADDR_W-1:0];
							p_d           = total_q;
							state_d       = sml_pkg::ST_INS_CMP;
						end
					end
					sml_pkg::CMD_REMOVE: begin
						state_d = sml_pkg::ST_RESP;
						if (total_q == '0) begin
							status_d = sml_pkg::STAT_EMPTY;
						end else if (!val_ok) begin
							status_d = sml_pkg::STAT_INVALID;
						end else if (cur_cnt == '0) begin
							status_d = sml_pkg::STAT_NOT_HELD;
						end else begin
							ram_req.re    = 1'b1;
							ram_req.raddr = '0;
							p_d           = '0;
							found_d       = 1'b0;
							state_d       = sml_pkg::ST_RM_RUN;
						end
					end
					sml_pkg::CMD_READ: begin
						if (total_q == '0) begin
							status_d = sml_pkg::STAT_EMPTY;
							state_d  = sml_pkg::ST_RESP;
						end else begin
							ram_req.re    = 1'b1;
							ram_req.raddr = '0;
							p_d           = '0;
							state_d       = sml_pkg::ST_RD_EMIT;
						end
					end
					default: begin
						// Unused command: no result, no change.
						state_d = sml_pkg::ST_IDLE;
					end
				endcase
			end

			sml_pkg::ST_INS_CMP: begin
				// Read data is the entry just below position p.
				if (ram_rdata > val_q) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = p_q[sml_pkg::ADDR_W-1:0];
					ram_req.wdata = ram_rdata;
					p_d           = p_m1;
					if (p_q > sml_pkg::CNT_W'(1)) begin
						ram_req.re    = 1'b1;
						ram_req.raddr = p_m2[sml_pkg::ADDR_W-1:0];
					end else begin
						state_d = sml_pkg::ST_INS_PUT;
					end
				end else begin
					ram_req.we    = 1'b1;
					ram_req.waddr = p_q[sml_pkg::ADDR_W-1:0];
					ram_req.wdata = val_q;
					status_d      = sml_pkg::STAT_OK;
					state_d       = sml_pkg::ST_RESP;
				end
			end

			sml_pkg::ST_INS_PUT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = p_q[sml_pkg::ADDR_W-1:0];
				ram_req.wdata = val_q;
				status_d      = sml_pkg::STAT_OK;
				state_d       = sml_pkg::ST_RESP;
			end

			sml_pkg::ST_RM_RUN: begin
				// Single pass: once the match is seen, each later entry moves down one.
				if (found_q) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = p_m1[sml_pkg::ADDR_W-1:0];
					ram_req.wdata = ram_rdata;
				end
				found_d = found_q | (ram_rdata == val_q);
				if (rd_last) begin
					status_d = found_d ? sml_pkg::STAT_OK : sml_pkg::STAT_NOT_HELD;
					state_d  = sml_pkg::ST_RESP;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = p_p1[sml_pkg::ADDR_W-1:0];
					p_d           = p_p1;
				end
			end

			sml_pkg::ST_RD_EMIT: begin
				res_valid = 1'b1;
				res       = '{status: sml_pkg::STAT_OK, entry: ram_rdata, last: rd_last};
				if (res_ready) begin
					if (rd_last) begin
						state_d = sml_pkg::ST_IDLE;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = p_p1[sml_pkg::ADDR_W-1:0];
						p_d           = p_p1;
					end
				end
			end

			sml_pkg::ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = sml_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = sml_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sml_pkg::ST_IDLE;
			p_q      <= '0;
			found_q  <= 1'b0;
			status_q <= sml_pkg::STAT_OK;
		end else begin
			state_q  <= state_d;
			p_q      <= p_d;
			found_q  <= found_d;
			status_q <= status_d;
		end
	end

	// Latched command
	always_ff @(posedge clk) begin
		if ((state_q == sml_pkg::ST_IDLE) && req_valid) begin
			op_q  <= req_cmd;
			val_q <= req_value;
		end
	end

	// Entry total and per-value counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int i = 0; i < sml_pkg::MAX_VALUE; i++) begin
				counts_q[i] <= '0;
			end
		end else if (commit) begin
			unique case (op_q)
				sml_pkg::CMD_INSERT: begin
					total_q        <= total_q + sml_pkg::CNT_W'(1);
					counts_q[cidx] <= counts_q[cidx] + sml_pkg::COPY_W'(1);
				end
				sml_pkg::CMD_REMOVE: begin
					total_q        <= tot_m1;
					counts_q[cidx] <= counts_q[cidx] - sml_pkg::COPY_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	`SML_ASSERT_NEVER(a_ins_pos_zero, (state_q == sml_pkg::ST_INS_CMP) && (p_q == '0), "insert shift reached position zero without a compare")
	`SML_ASSERT(a_rm_in_range, (state_q == sml_pkg::ST_RM_RUN) |-> (p_q < total_q), "remove scan ran past the list end")
	`SML_ASSERT(a_rd_advance, ((state_q == sml_pkg::ST_RD_EMIT) && res_ready && !rd_last) |=> ((state_q == sml_pkg::ST_RD_EMIT) && (p_q == $past(p_p1))), "read stream skipped or repeated an entry")
	`SML_ASSERT(a_total_commit, !$stable(total_q) |-> $past(commit), "entry total changed outside a result transfer")

endmodule

@@ src/sorted_multiset_list_core.sv @@
// Top level of the sorted multiset list: configuration registers, output register,
// sequencer and entry memory. Depends on sml_pkg, the sml interfaces, sml_seq and sml_ram.
// Usage:
//   req carries one command (insert, remove or read) with a value. It is taken only
//   while the sequencer is idle; a command is one transfer.
//   rsp carries results. Insert and remove answer with one result (status, last set).
//   Read answers with one result per held entry in ascending order, last on the final
//   one, or a single empty result when nothing is held. Command 3 gives no result.
//   cfg writes list_limit (index 0) and copy_limit (index 1); it is always ready and
//   other indexes are dropped. Write it only while no command is in progress.
// Command steps:
//   A refused command is taken, checked and answered. An insert also shifts each larger
//   entry up and places the value, a remove scans the entries and moves each one after
//   the match down, and a read sends each entry. Results reach rsp via the output register.
// Reset:
//   arst_n empties the list, clears all counts and loads limits 20 and 4. The entry
//   memory itself is not cleared; no entry is read before it is written.
// Stalls:
//   A result waits in the output register while rsp.ready is low; the sequencer
//   holds a step that hands over a result until the register frees up.
module sorted_multiset_list_core (
	input  logic        clk,
	input  logic        arst_n,
	sml_req_if.sink     req,
	sml_rsp_if.source   rsp,
	sml_cfg_if.sink     cfg
);

	logic [sml_pkg::LIMIT_W-1:0]   list_limit_q;
	logic [sml_pkg::COPY_W-1:0]    copy_limit_q;
	logic [sml_pkg::LIM_CMP_W-1:0] limit_ext;
	sml_pkg::sml_cfg_t             seq_cfg;

	logic                          res_valid;
	logic                          res_ready;
	sml_pkg::sml_res_t             res;
	logic                          out_valid_q;
	sml_pkg::sml_res_t             out_res_q;

	sml_pkg::sml_ram_req_t         ram_req;
	logic [sml_pkg::VAL_W-1:0]     ram_rdata;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_limit_q <= sml_pkg::RESET_LIST_LIMIT;
			copy_limit_q <= sml_pkg::RESET_COPY_LIMIT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sml_pkg::REG_LIST_LIMIT: list_limit_q <= cfg.data;
				sml_pkg::REG_COPY_LIMIT: copy_limit_q <= cfg.data[sml_pkg::COPY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective list limit is the smaller of the register and the capacity.
	assign limit_ext = sml_pkg::LIM_CMP_W'(list_limit_q);
	assign seq_cfg.lim = (limit_ext < sml_pkg::LIM_CMP_W'(sml_pkg::CAPACITY)) ?
	                     sml_pkg::CNT_W'(list_limit_q) : sml_pkg::CNT_W'(sml_pkg::CAPACITY);
	assign seq_cfg.copy_limit = copy_limit_q;

	sml_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_value (req.value),
		.req_ready (req.ready),
		.cfg       (seq_cfg),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	sml_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Output register between the sequencer and the result channel
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_res_q.status;
	assign rsp.entry  = out_res_q.entry;
	assign rsp.last   = out_res_q.last;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_multiset_list_core: drives commands and register writes,
// predicts every result with a shadow copy of the list and checks each transfer.
// Depends on sml_pkg, the sml interfaces and the RTL of the block.
module tb;
	import sml_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES  = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int SHOW_MAX     = 40;

	// Command code with no meaning to the block, and register indexes it drops.
	localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// One row of the opening table; st is used only where given is set.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] value;
		bit               given;
		status_t          st;
	} opening_row_t;

	// Status written into the table, carried from drive to acceptance.
	typedef struct packed {
		bit      given;
		status_t st;
	} typed_status_t;

	// Register setting, idling and command mix of one phase.
	typedef struct packed {
		logic [CFG_DATA_W-1:0] lim;
		logic [CFG_DATA_W-1:0] copy;
		int                    send_idle;
		int                    rsp_stall;
		int                    items;
		int                    ins_pct;
		int                    hold_at;
	} phase_t;

	localparam int N_OPENING = 23;
	localparam int N_PHASES  = 8;

	// Opening table: empty list answers, bad values, copy limit, shifts and reads.
	opening_row_t opening_rows [N_OPENING] = '{
		'{CMD_READ,   4'd0,  1'b1, STAT_EMPTY},
		'{CMD_REMOVE, 4'd5,  1'b1, STAT_EMPTY},
		'{CMD_INSERT, 4'd0,  1'b1, STAT_INVALID},
		'{CMD_INSERT, 4'd15, 1'b1, STAT_INVALID},
		'{CMD_INSERT, 4'd14, 1'b1, STAT_INVALID},
		'{CMD_INSERT, 4'd13, 1'b1, STAT_OK},
		'{CMD_INSERT, 4'd1,  1'b1, STAT_OK},
		'{CMD_INSERT, 4'd7,  1'b0, STAT_OK},
		'{CMD_INSERT, 4'd7,  1'b0, STAT_OK},
		'{CMD_INSERT, 4'd7,  1'b0, STAT_OK},
		'{CMD_INSERT, 4'd7,  1'b0, STAT_OK},
		'{CMD_INSERT, 4'd7,  1'b1, STAT_COPY},
		'{CMD_REMOVE, 4'd0,  1'b1, STAT_INVALID},
		'{CMD_REMOVE, 4'd15, 1'b1, STAT_INVALID},
		'{CMD_REMOVE, 4'd4,  1'b1, STAT_NOT_HELD},
		'{CMD_UNUSED, 4'd15, 1'b0, STAT_OK},
		'{CMD_READ,   4'd10, 1'b0, STAT_OK},
		'{CMD_INSERT, 4'd8,  1'b0, STAT_OK},
		'{CMD_INSERT, 4'd2,  1'b0, STAT_OK},
		'{CMD_REMOVE, 4'd7,  1'b0, STAT_OK},
		'{CMD_REMOVE, 4'd13, 1'b0, STAT_OK},
		'{CMD_REMOVE, 4'd1,  1'b0, STAT_OK},
		'{CMD_READ,   4'd0,  1'b0, STAT_OK}
	};

	// Random phases: wide and clamped limits, a limit below the fill, zero limits.
	phase_t plan [N_PHASES] = '{
		'{6'd32, 6'h3F, 0,  0,  60, 55, -1},
		'{6'd3,  6'd1,  74, 0,  40, 50, -1},
		'{6'd63, 6'd7,  0,  74, 90, 75, 40},
		'{6'd5,  6'h08, 20, 20, 40, 50, -1},
		'{6'd0,  6'd3,  0,  0,  20, 50, -1},
		'{6'd12, 6'd2,  20, 20, 70, 50, -1},
		'{6'd1,  6'd1,  74, 0,  30, 50, -1},
		'{6'd20, 6'd4,  0,  0,  50, 50, -1}
	};

	logic clk = 1'b0;
	logic arst_n;

	sml_req_if req_ch();
	sml_rsp_if rsp_ch();
	sml_cfg_if cfg_ch();

	sorted_multiset_list_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the list, its counts and the two registers.
	logic [VAL_W-1:0]   shadow_list   [CAPACITY];
	logic [CNT_W-1:0]   shadow_total  = '0;
	logic [COPY_W-1:0]  shadow_counts [MAX_VALUE];
	logic [LIMIT_W-1:0] shadow_lim    = RESET_LIST_LIMIT;
	logic [COPY_W-1:0]  shadow_copy   = RESET_COPY_LIMIT;

	sml_res_t      due_results [$];
	typed_status_t typed_q     [$];
	sml_res_t      want;

	int err_count     = 0;
	int cmds_taken    = 0;
	int results_seen  = 0;
	int regs_written  = 0;
	int send_idle     = 0;
	int rsp_stall     = 0;
	int hold_asked    = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("%0t ns: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
		$display("FAIL");
		$finish;
	end

	// Insert into the shadow list: full first, then bad value, then copy limit.
	task automatic shadow_insert(input int v, output status_t st);
		int pos;
		int eff;
		eff = (int'(shadow_lim) < CAPACITY) ? int'(shadow_lim) : CAPACITY;
		if (int'(shadow_total) >= eff) begin
			st = STAT_FULL;
		end else if (v < 1 || v > MAX_VALUE) begin
			st = STAT_INVALID;
		end else if (shadow_counts[v-1] >= shadow_copy) begin
			st = STAT_COPY;
		end else begin
			// Larger entries move up one place; the value lands after its equals.
			pos = shadow_total;
			while (pos > 0 && shadow_list[pos-1] > v) begin
				shadow_list[pos] = shadow_list[pos-1];
				pos--;
			end
			shadow_list[pos] = v;
			shadow_total++;
			shadow_counts[v-1]++;
			st = STAT_OK;
		end
	endtask

	// Remove one occurrence: empty first, then bad value, then not held.
	task automatic shadow_remove(input int v, output status_t st);
		int pos;
		if (shadow_total == 0) begin
			st = STAT_EMPTY;
		end else if (v < 1 || v > MAX_VALUE) begin
			st = STAT_INVALID;
		end else if (shadow_counts[v-1] == 0) begin
			st = STAT_NOT_HELD;
		end else begin
			pos = 0;
			while (pos < int'(shadow_total) && shadow_list[pos] != v) pos++;
			// Later entries close the gap.
			while (pos + 1 < int'(shadow_total)) begin
				shadow_list[pos] = shadow_list[pos+1];
				pos++;
			end
			shadow_total--;
			shadow_counts[v-1]--;
			st = STAT_OK;
		end
	endtask

	// Work out the results of one accepted command and queue them.
	task automatic take_command(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v);
		typed_status_t tag;
		status_t       st;
		tag = '0;
		if (typed_q.size() != 0) tag = typed_q.pop_front();
		case (c)
			CMD_INSERT: begin
				shadow_insert(int'(v), st);
				due_results.push_back('{tag.given ? tag.st : st, 4'd0, 1'b1});
			end
			CMD_REMOVE: begin
				shadow_remove(int'(v), st);
				due_results.push_back('{tag.given ? tag.st : st, 4'd0, 1'b1});
			end
			CMD_READ: begin
				if (shadow_total == 0) begin
					due_results.push_back('{tag.given ? tag.st : STAT_EMPTY, 4'd0, 1'b1});
				end else begin
					for (int k = 0; k < int'(shadow_total); k++)
						due_results.push_back('{STAT_OK, shadow_list[k],
							k + 1 == int'(shadow_total)});
				end
			end
			default: begin
				// The unused command changes nothing and answers nothing.
			end
		endcase
	endtask

	task automatic check_field(input string what, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			err_count++;
			if (err_count <= SHOW_MAX)
				$display("%0t ns: %s mismatch, expected %0d, got %0d",
					$time, what, exp_val, got_val);
		end
	endtask

	// Command transfers feed the shadow list.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			take_command(req_ch.cmd, req_ch.value);
			cmds_taken++;
		end
	end

	// Register transfers update the shadow registers; other indexes are dropped.
	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_LIST_LIMIT: shadow_lim = cfg_ch.data;
				REG_COPY_LIMIT: shadow_copy = cfg_ch.data[COPY_W-1:0];
				default: ;
			endcase
			regs_written++;
		end
	end

	// Each result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				err_count++;
				if (err_count <= SHOW_MAX)
					$display("%0t ns: result with nothing expected, got status %0d entry %0d last %0d",
						$time, rsp_ch.status, rsp_ch.entry, rsp_ch.last);
			end else begin
				want = due_results.pop_front();
				check_field("status", want.status, rsp_ch.status);
				check_field("entry", want.entry, rsp_ch.entry);
				check_field("last", want.last, rsp_ch.last);
				results_seen++;
			end
		end
	end

	// Result side: random stalls, and on request one long hold-off.
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall);
		end
	end

	// Offer one command and wait for its transfer; valid stays high afterwards.
	task automatic send_command(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v,
		input bit given, input status_t st);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.value <= v;
		typed_q.push_back('{given, st});
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Drop valid, wait for every expected result, then let the block go quiet.
	// The first edge lets the last command transfer reach the shadow list.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed traffic: valid values, removes of held values.
	task automatic pick_command(input int ins_pct, output logic [CMD_W-1:0] c,
		output logic [VAL_W-1:0] v);
		int r;
		r = $urandom_range(99);
		v = $urandom_range(15);
		if (r < ins_pct) begin
			c = CMD_INSERT;
			if ($urandom_range(99) >= 8) v = $urandom_range(MAX_VALUE, 1);
		end else begin
			r = $urandom_range(99);
			if (r < 62) begin
				c = CMD_REMOVE;
				if (shadow_total != 0 && $urandom_range(99) < 75)
					v = shadow_list[$urandom_range(int'(shadow_total) - 1)];
			end else if (r < 94) begin
				c = CMD_READ;
			end else begin
				c = CMD_UNUSED;
			end
		end
	endtask

	initial begin
		logic [CMD_W-1:0] c;
		logic [VAL_W-1:0] v;
		int               n;
		bit               hold_done;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		for (int i = 0; i < MAX_VALUE; i++) shadow_counts[i] = '0;
		for (int i = 0; i < CAPACITY; i++) shadow_list[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening table under the reset limits, no idling.
		foreach (opening_rows[i])
			send_command(opening_rows[i].cmd, opening_rows[i].value,
				opening_rows[i].given, opening_rows[i].st);
		settle();

		// Random phases, each with its own limits and idling.
		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(REG_LIST_LIMIT, plan[p].lim);
			write_reg(REG_COPY_LIMIT, plan[p].copy);
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(63));
			cfg_ch.valid <= 1'b0;
			send_idle = plan[p].send_idle;
			rsp_stall = plan[p].rsp_stall;
			n = 0;
			hold_done = 1'b0;
			while (n < plan[p].items) begin
				if (n == plan[p].hold_at && !hold_done) begin
					hold_asked++;
					hold_done = 1'b1;
				end
				pick_command(plan[p].ins_pct, c, v);
				send_command(c, v, 1'b0, STAT_OK);
				if (c != CMD_UNUSED) n++;
			end
			settle();
		end

		// Any expectation still queued is a result that never came.
		if (due_results.size() != 0) begin
			err_count++;
			$display("%0t ns: results missing, expected %0d more, got 0",
				$time, due_results.size());
		end

		$display("Checked %0d results from %0d commands over %0d register writes,",
			results_seen, cmds_taken, regs_written);
		$display("with list limits from 0 to 63, copy limits from 0 to 7 and long stalls.");
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
